// ===== hw/rtl/interval_paint_run_tracker_unit_defines.svh =====
// assertion macros shared by the interval paint run tracker rtl
`ifndef INTERVAL_PAINT_RUN_TRACKER_UNIT_DEFINES_SVH
`define INTERVAL_PAINT_RUN_TRACKER_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, checked on clk, off while in reset
`define IPRT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("iprt assertion failed");
// next-cycle implication
`define IPRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("iprt assertion failed");
`else
`define IPRT_ASSERT_IMPL(lbl, ante, cons)
`define IPRT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/iprt_pkg.sv =====
// shared types and constants of the interval paint run tracker
package iprt_pkg;

  localparam int unsigned IDX_W    = 10;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned RUNS_W   = 10;
  localparam int unsigned TOTAL_W  = 42;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PAINT = 1'b1;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                load;
    logic                paint;
    logic                shift;
    logic [IDX_W-1:0]    first;
    logic [IDX_W-1:0]    last;
    logic                color;
    logic [WEIGHT_W-1:0] weight;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/iprt_cell.sv =====
// one cell of the row: colour and weight, with paint, load and ring shift
module iprt_cell
  import iprt_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned XW  = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cell_cmd_t           cmd_i,
  input  logic                nb_color_i,
  input  logic [WEIGHT_W-1:0] nb_weight_i,
  output logic                color_o,
  output logic [WEIGHT_W-1:0] weight_o
);

  localparam logic [XW-1:0] MY_IDX = XW'(IDX);

  logic                color_r, color_nxt;
  logic [WEIGHT_W-1:0] weight_r, weight_nxt;
  logic [XW-1:0]       first_x, last_x;
  logic                paint_hit, load_hit;

  assign first_x   = XW'(cmd_i.first);
  assign last_x    = XW'(cmd_i.last);
  // a range end past the row never matters: no cell sits beyond it
  assign paint_hit = cmd_i.paint && (first_x <= MY_IDX) && (MY_IDX <= last_x);
  assign load_hit  = cmd_i.load && (first_x == MY_IDX);

  always_comb begin
    color_nxt  = color_r;
    weight_nxt = weight_r;
    if (cmd_i.shift) begin
      color_nxt  = nb_color_i;
      weight_nxt = nb_weight_i;
    end else begin
      if (paint_hit) color_nxt  = cmd_i.color;
      if (load_hit)  weight_nxt = cmd_i.weight;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r  <= 1'b0;
      weight_r <= '0;
    end else begin
      color_r  <= color_nxt;
      weight_r <= weight_nxt;
    end
  end

  assign color_o  = color_r;
  assign weight_o = weight_r;

endmodule

// ===== hw/rtl/iprt_tally.sv =====
// run and weight accumulator fed by the head of the cell ring
module iprt_tally
  import iprt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clear_i,
  input  logic                step_i,
  input  logic                color_i,
  input  logic [WEIGHT_W-1:0] weight_i,
  output logic [RUNS_W-1:0]   runs_o,
  output logic [TOTAL_W-1:0]  total_o
);

  logic                prev_r, prev_nxt;
  logic [RUNS_W-1:0]   runs_r, runs_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;

  always_comb begin
    prev_nxt  = prev_r;
    runs_nxt  = runs_r;
    total_nxt = total_r;
    if (clear_i) begin
      prev_nxt  = 1'b0;
      runs_nxt  = '0;
      total_nxt = '0;
    end else if (step_i) begin
      prev_nxt = color_i;
      // a run opens on a black cell after a white one
      if (color_i && !prev_r) runs_nxt = runs_r + RUNS_W'(1);
      if (color_i) total_nxt = total_r + TOTAL_W'(weight_i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 1'b0;
      runs_r  <= '0;
      total_r <= '0;
    end else begin
      prev_r  <= prev_nxt;
      runs_r  <= runs_nxt;
      total_r <= total_nxt;
    end
  end

  assign runs_o  = runs_r;
  assign total_o = total_r;

endmodule

// ===== hw/rtl/interval_paint_run_tracker_unit.sv =====
// top level of the interval paint run tracker: cell ring, tally and control
//
//   channel | direction | handshake           | beat holds
//   in      | input     | in_valid / in_ready | op, first/last index, colour, weight
//   out     | output    | out_valid/out_ready | black_runs, black_weight
//
// a load: the addressed cell latches the weight on acceptance
// a paint marks its range on acceptance, then the ring rotates once through
// the tally, and the result is registered from push once the output slot is free
// in_ready is high only in idle, so the next beat after a paint waits out the sweep and push
// loads and paints are taken while an earlier result waits
// a stalled result holds the next paint before its output register, never the ring
// synchronous reset: all cells white with zero weight, no result pending
`include "interval_paint_run_tracker_unit_defines.svh"
module interval_paint_run_tracker_unit
  import iprt_pkg::*;
#(
  parameter int unsigned CELLS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic [IDX_W-1:0]    in_first_index,
  input  logic [IDX_W-1:0]    in_last_index,
  input  logic                in_paint_color,
  input  logic [WEIGHT_W-1:0] in_cell_weight,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [RUNS_W-1:0]   out_black_runs,
  output logic [TOTAL_W-1:0]  out_black_weight
);

  localparam int unsigned CW = $clog2(CELLS);
  localparam int unsigned XW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [CW-1:0] LAST_STEP = CW'(CELLS - 1);

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_PUSH} state_t;

  state_t              state_r;
  logic [CW-1:0]       cnt_r;
  logic                out_valid_r, out_valid_nxt;
  logic [RUNS_W-1:0]   out_runs_r;
  logic [TOTAL_W-1:0]  out_total_r;

  cell_cmd_t           cmd;
  logic                in_fire, slot_free;
  logic                sweep_step;
  logic [CELLS-1:0]    color_w;
  logic [WEIGHT_W-1:0] weight_w [CELLS];
  logic [RUNS_W-1:0]   tally_runs;
  logic [TOTAL_W-1:0]  tally_total;

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign slot_free  = !out_valid_r || out_ready;
  assign sweep_step = (state_r == S_SWEEP);

  always_comb begin
    cmd.load   = in_fire && (in_op == OP_LOAD);
    cmd.paint  = in_fire && (in_op == OP_PAINT);
    cmd.shift  = sweep_step;
    cmd.first  = in_first_index;
    cmd.last   = in_last_index;
    cmd.color  = in_paint_color;
    cmd.weight = in_cell_weight;
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if ((state_r == S_PUSH) && slot_free) out_valid_nxt = 1'b1;
  end

  // ring: each cell takes its upper neighbour, the top cell takes cell zero
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    iprt_cell #(
      .IDX (i),
      .XW  (XW)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd_i       (cmd),
      .nb_color_i  (color_w[(i + 1) % CELLS]),
      .nb_weight_i (weight_w[(i + 1) % CELLS]),
      .color_o     (color_w[i]),
      .weight_o    (weight_w[i])
    );
  end

  iprt_tally u_tally (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear_i  (cmd.paint),
    .step_i   (sweep_step),
    .color_i  (color_w[0]),
    .weight_i (weight_w[0]),
    .runs_o   (tally_runs),
    .total_o  (tally_total)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (cmd.paint) begin
            state_r <= S_SWEEP;
            cnt_r   <= '0;
          end
        end
        S_SWEEP: begin
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == LAST_STEP) state_r <= S_PUSH;
        end
        S_PUSH: begin
          if (slot_free) begin
            out_runs_r  <= tally_runs;
            out_total_r <= tally_total;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_black_runs   = out_runs_r;
  assign out_black_weight = out_total_r;

  `IPRT_ASSERT_IMPL(a_result_from_push, out_valid && !$past(out_valid), $past(state_r == S_PUSH))
  `IPRT_ASSERT_NEXT(a_paint_starts_sweep, cmd.paint, sweep_step && cnt_r == '0)
  `IPRT_ASSERT_NEXT(a_sweep_advances, sweep_step && cnt_r != LAST_STEP, cnt_r == $past(cnt_r) + CW'(1))

endmodule
